### rtl/iirq_pkg.sv
// Shared types and constants for the fourth-order direct form I IIR filter.
// Used by iirq_dsmac and iir_order4_direct_form1_q14; no dependencies.
package iirq_pkg;

    localparam int DIGIT_W    = 4;
    localparam int COEF_W     = 16;
    localparam int COEF_EXT_W = COEF_W + 1;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0     = 3'd0,
        REG_B1     = 3'd1,
        REG_B2     = 3'd2,
        REG_B3     = 3'd3,
        REG_B4     = 3'd4,
        REG_A1_A2  = 3'd5,
        REG_A3_A4  = 3'd6
    } t_reg_idx;

endpackage

### rtl/iir_order4_direct_form1_q14.sv
// Top level of the direct form I IIR filter with Q14 coefficients.
// Depends on iirq_pkg and iirq_dsmac.
//
// Each accepted sample yields one saturated output sample. The 2*ORDER+1 taps
// (b0..bP against current and past inputs, -a1..-aP against past outputs) run
// one after another through a single digit-serial multiplier that consumes 4
// operand bits per cycle. After a sample is accepted each tap is loaded and
// multiplied in turn; the sum is then shifted down by FRAC_BITS and saturated.
// The block works on one sample at a time; a finished result sits in an output
// register while the next sample is accepted. Coefficient writes are taken
// every cycle and must only be made while the filter is idle.
module iir_order4_direct_form1_q14 #(
    parameter int FILTER_ORDER_P = 4,
    parameter int FRAC_BITS      = 14,
    parameter int SAMPLE_WIDTH   = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [iirq_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [iirq_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_sample_in,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]         o_sample_out,
    output logic                                   o_saturated
);

    localparam int SW     = SAMPLE_WIDTH;
    localparam int NDIG   = (SW + iirq_pkg::DIGIT_W - 1) / iirq_pkg::DIGIT_W;
    localparam int OPD_W  = NDIG * iirq_pkg::DIGIT_W;
    localparam int PW     = iirq_pkg::COEF_EXT_W + OPD_W;
    localparam int NTAP   = 2 * FILTER_ORDER_P + 1;
    localparam int TW     = $clog2(NTAP);
    localparam int AW     = PW + TW;
    localparam int HW     = (FILTER_ORDER_P > 1) ? $clog2(FILTER_ORDER_P) : 1;
    localparam int KW     = (TW < 3) ? 3 : TW;
    localparam int CEW    = iirq_pkg::COEF_EXT_W;
    localparam int CFW    = iirq_pkg::COEF_W;

    localparam logic [TW-1:0]        TAP_LAST = TW'(NTAP - 1);
    localparam logic signed [AW-1:0] Y_MAX    = AW'((1 << (SW - 1)) - 1);
    localparam logic signed [AW-1:0] Y_MIN    = AW'(-(1 << (SW - 1)));

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_WAIT,
        S_SAT
    } t_state;

    t_state                   r_state;
    logic [TW-1:0]            r_tap;
    logic signed [AW-1:0]     r_acc;
    logic signed [SW-1:0]     r_x;
    logic signed [SW-1:0]     r_past_in  [FILTER_ORDER_P];
    logic signed [SW-1:0]     r_past_out [FILTER_ORDER_P];
    logic                     r_out_valid;
    logic signed [SW-1:0]     r_out;
    logic                     r_out_sat;

    logic [CFW-1:0]                  r_coef_b [5];
    logic [iirq_pkg::CFG_DATA_W-1:0] r_coef_a12;
    logic [iirq_pkg::CFG_DATA_W-1:0] r_coef_a34;

    logic [TW-1:0]            w_half;
    logic [TW-1:0]            w_half_m1;
    logic [KW-1:0]            w_kb;
    logic [KW-1:0]            w_ka;
    logic signed [SW-1:0]     w_sel;
    logic signed [OPD_W-1:0]  w_opd;
    logic [CFW-1:0]           w_cb;
    logic [CFW-1:0]           w_ca;
    logic signed [CEW-1:0]    w_coef;
    logic                     w_mac_load;
    logic                     w_mac_busy;
    logic signed [PW-1:0]     w_part;
    logic signed [AW-1:0]     w_sh;
    logic signed [SW-1:0]     w_y;
    logic                     w_sat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) begin
                r_coef_b[k] <= '0;
            end
            r_coef_a12 <= '0;
            r_coef_a34 <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (iirq_pkg::t_reg_idx'(i_cfg_index))
                iirq_pkg::REG_B0:    r_coef_b[0] <= i_cfg_data[CFW-1:0];
                iirq_pkg::REG_B1:    r_coef_b[1] <= i_cfg_data[CFW-1:0];
                iirq_pkg::REG_B2:    r_coef_b[2] <= i_cfg_data[CFW-1:0];
                iirq_pkg::REG_B3:    r_coef_b[3] <= i_cfg_data[CFW-1:0];
                iirq_pkg::REG_B4:    r_coef_b[4] <= i_cfg_data[CFW-1:0];
                iirq_pkg::REG_A1_A2: r_coef_a12  <= i_cfg_data;
                iirq_pkg::REG_A3_A4: r_coef_a34  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_half    = r_tap >> 1;
        w_half_m1 = w_half - TW'(1);
        w_ka      = KW'(w_half);
        if (r_tap == '0) begin
            w_kb = '0;
        end else begin
            w_kb = KW'(w_half) + KW'(1);
        end

        if (r_tap == '0) begin
            w_sel = r_x;
        end else if (r_tap[0]) begin
            w_sel = r_past_in[w_half[HW-1:0]];
        end else begin
            w_sel = r_past_out[w_half_m1[HW-1:0]];
        end
        w_opd = OPD_W'(w_sel);

        case (w_kb)
            KW'(0):  w_cb = r_coef_b[0];
            KW'(1):  w_cb = r_coef_b[1];
            KW'(2):  w_cb = r_coef_b[2];
            KW'(3):  w_cb = r_coef_b[3];
            KW'(4):  w_cb = r_coef_b[4];
            default: w_cb = '0;
        endcase
        case (w_ka)
            KW'(1):  w_ca = r_coef_a12[CFW-1:0];
            KW'(2):  w_ca = r_coef_a12[2*CFW-1:CFW];
            KW'(3):  w_ca = r_coef_a34[CFW-1:0];
            KW'(4):  w_ca = r_coef_a34[2*CFW-1:CFW];
            default: w_ca = '0;
        endcase

        if (r_tap == '0 || r_tap[0]) begin
            w_coef = {w_cb[CFW-1], w_cb};
        end else begin
            w_coef = -$signed({w_ca[CFW-1], w_ca});
        end
    end

    assign w_mac_load = (r_state == S_LOAD);

    iirq_dsmac #(
        .OPD_W (OPD_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_mac_load),
        .i_opd   (w_opd),
        .i_coef  (w_coef),
        .o_busy  (w_mac_busy),
        .o_part  (w_part)
    );

    always_comb begin
        w_sh = r_acc >>> FRAC_BITS;
        if (w_sh > Y_MAX) begin
            w_y   = SW'(Y_MAX);
            w_sat = 1'b1;
        end else if (w_sh < Y_MIN) begin
            w_y   = SW'(Y_MIN);
            w_sat = 1'b1;
        end else begin
            w_y   = w_sh[SW-1:0];
            w_sat = 1'b0;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;
    assign o_saturated  = r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < FILTER_ORDER_P; k++) begin
                r_past_in[k]  <= '0;
                r_past_out[k] <= '0;
            end
        end else begin
            if (r_out_valid && i_out_ready && r_state != S_SAT) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x     <= i_sample_in;
                        r_tap   <= '0;
                        r_acc   <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (!w_mac_busy) begin
                        r_acc <= r_acc + AW'(w_part);
                        if (r_tap == TAP_LAST) begin
                            r_state <= S_SAT;
                        end else begin
                            r_tap   <= r_tap + TW'(1);
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_SAT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out       <= w_y;
                        r_out_sat   <= w_sat;
                        r_out_valid <= 1'b1;
                        for (int k = FILTER_ORDER_P - 1; k > 0; k--) begin
                            r_past_in[k]  <= r_past_in[k-1];
                            r_past_out[k] <= r_past_out[k-1];
                        end
                        r_past_in[0]  <= r_x;
                        r_past_out[0] <= w_y;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_idle_mac_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_mac_busy)
        else $error("multiplier busy while filter idle");

    a_valid_from_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_SAT))
        else $error("output valid raised outside saturation step");

    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sat) |->
            (r_out == SW'(Y_MAX) || r_out == SW'(Y_MIN)))
        else $error("saturated flag set on an unclipped sample");

    a_wait_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> (r_state == S_WAIT && w_mac_busy))
        else $error("multiplier did not start after tap load");
`endif

endmodule

### rtl/iirq_dsmac.sv
// Digit-serial multiplier: a shift register feeds the operand MSB digit first
// into a narrow multiply against a held coefficient. Depends on iirq_pkg.
module iirq_dsmac #(
    parameter int OPD_W = 16
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_load,
    input  logic signed [OPD_W-1:0]                          i_opd,
    input  logic signed [iirq_pkg::COEF_EXT_W-1:0]           i_coef,
    output logic                                             o_busy,
    output logic signed [iirq_pkg::COEF_EXT_W+OPD_W-1:0]     o_part
);

    localparam int NDIG = OPD_W / iirq_pkg::DIGIT_W;
    localparam int CW   = $clog2(NDIG + 1);
    localparam int PW   = iirq_pkg::COEF_EXT_W + OPD_W;
    localparam int MW   = iirq_pkg::COEF_EXT_W + iirq_pkg::DIGIT_W + 1;

    logic        [OPD_W-1:0]                   r_opd;
    logic signed [iirq_pkg::COEF_EXT_W-1:0]    r_coef;
    logic signed [PW-1:0]                      r_part;
    logic        [CW-1:0]                      r_cnt;

    logic        [iirq_pkg::DIGIT_W-1:0]       w_dig;
    logic signed [iirq_pkg::DIGIT_W:0]         w_dig_s;
    logic signed [MW-1:0]                      w_prod;
    logic signed [PW-1:0]                      n_part;

    always_comb begin
        w_dig = r_opd[OPD_W-1 -: iirq_pkg::DIGIT_W];
        if (r_cnt == CW'(NDIG)) begin
            w_dig_s = {w_dig[iirq_pkg::DIGIT_W-1], w_dig};
        end else begin
            w_dig_s = {1'b0, w_dig};
        end
        w_prod = MW'(r_coef) * MW'(w_dig_s);
        n_part = (r_part <<< iirq_pkg::DIGIT_W) + PW'(w_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= CW'(NDIG);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_opd  <= i_opd;
            r_coef <= i_coef;
            r_part <= '0;
        end else if (r_cnt != '0) begin
            r_opd  <= r_opd << iirq_pkg::DIGIT_W;
            r_part <= n_part;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_part = r_part;

endmodule

### tb/iir_order4_direct_form1_q14_checker.sv
`timescale 1ns / 1ps
// Checker for iir_order4_direct_form1_q14: watches the coefficient, sample and output channels,
// predicts every output sample and compares it field by field. Depends on iirq_pkg.
module iir_order4_direct_form1_q14_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [iirq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [iirq_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic signed [15:0]                  i_sample_in,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [15:0]                  i_sample_out,
    input  logic                                i_saturated,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int     ORDER    = 4;
    localparam int     FRAC     = 14;
    localparam int     SAMPLE_W = 16;
    localparam longint SAT_MAX  = (longint'(1) << (SAMPLE_W - 1)) - 1;
    localparam longint SAT_MIN  = -SAT_MAX - 1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       saturated;
    } t_filt_out;

    logic signed [iirq_pkg::COEF_W-1:0] coef_b [0:ORDER];
    logic signed [iirq_pkg::COEF_W-1:0] coef_a [1:ORDER];
    logic signed [SAMPLE_W-1:0]         x_hist [0:ORDER-1];
    logic signed [SAMPLE_W-1:0]         y_hist [0:ORDER-1];
    t_filt_out                          expected_q [$];
    int                                 fail_count = 0;
    int                                 out_count  = 0;

    task automatic report_mismatch(input string field, input int item, input longint got,
                                   input longint want);
        $display("MISMATCH output %0d %s: got %0d, expected %0d", item, field, got, want);
        fail_count++;
    endtask

    task automatic clear_filter();
        for (int k = 0; k <= ORDER; k++) begin
            coef_b[k] = '0;
        end
        for (int k = 1; k <= ORDER; k++) begin
            coef_a[k] = '0;
        end
        for (int k = 0; k < ORDER; k++) begin
            x_hist[k] = '0;
            y_hist[k] = '0;
        end
        expected_q.delete();
    endtask

    task automatic write_coef(input logic [iirq_pkg::CFG_IDX_W-1:0] idx,
                              input logic [iirq_pkg::CFG_DATA_W-1:0] data);
        case (iirq_pkg::t_reg_idx'(idx))
            iirq_pkg::REG_B0:    coef_b[0] = data[15:0];
            iirq_pkg::REG_B1:    coef_b[1] = data[15:0];
            iirq_pkg::REG_B2:    coef_b[2] = data[15:0];
            iirq_pkg::REG_B3:    coef_b[3] = data[15:0];
            iirq_pkg::REG_B4:    coef_b[4] = data[15:0];
            iirq_pkg::REG_A1_A2: begin
                coef_a[1] = data[15:0];
                coef_a[2] = data[31:16];
            end
            iirq_pkg::REG_A3_A4: begin
                coef_a[3] = data[15:0];
                coef_a[4] = data[31:16];
            end
            default: ;
        endcase
    endtask

    function automatic t_filt_out filter_step(input logic signed [SAMPLE_W-1:0] x);
        longint    acc;
        longint    y;
        t_filt_out r;
        acc = longint'(coef_b[0]) * longint'(x);
        for (int k = 1; k <= ORDER; k++) begin
            acc = acc + longint'(coef_b[k]) * longint'(x_hist[k-1])
                      - longint'(coef_a[k]) * longint'(y_hist[k-1]);
        end
        // arithmetic shift floors toward minus infinity
        y = acc >>> FRAC;
        r.saturated = 1'b0;
        if (y > SAT_MAX) begin
            y = SAT_MAX;
            r.saturated = 1'b1;
        end else if (y < SAT_MIN) begin
            y = SAT_MIN;
            r.saturated = 1'b1;
        end
        r.sample = y[SAMPLE_W-1:0];
        for (int k = ORDER - 1; k > 0; k--) begin
            x_hist[k] = x_hist[k-1];
            y_hist[k] = y_hist[k-1];
        end
        x_hist[0] = x;
        y_hist[0] = r.sample;
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_filt_out want;
        if (!i_rst_n) begin
            clear_filter();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                write_coef(i_cfg_index, i_cfg_data);
            end
            if (i_out_valid && i_out_ready) begin
                out_count++;
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected transfer", out_count,
                                    longint'(i_sample_out), longint'(0));
                end else begin
                    want = expected_q.pop_front();
                    if (i_sample_out !== want.sample) begin
                        report_mismatch("sample_out", out_count,
                                        longint'(i_sample_out), longint'(want.sample));
                    end
                    if (i_saturated !== want.saturated) begin
                        report_mismatch("saturated", out_count,
                                        longint'(i_saturated), longint'(want.saturated));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_q.push_back(filter_step(i_sample_in));
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_count;
    end

endmodule

### tb/iir_order4_direct_form1_q14_tb.sv
`timescale 1ns / 1ps
// Testbench top for iir_order4_direct_form1_q14: drives coefficient writes and samples with
// random gaps and output stalls, and gives the verdict. Depends on iirq_pkg and the checker.
module iir_order4_direct_form1_q14_tb;

    localparam logic [iirq_pkg::CFG_IDX_W-1:0] UNUSED_REG_IDX = 3'd7;
    localparam int                   RANDOM_ITEMS   = 1700;
    localparam int                   FIRST_PHASE    = 300;
    localparam int                   HOLD_AT        = 40;
    localparam int                   HOLD_CYCLES    = 600;
    localparam int                   CYCLE_LIMIT    = 1000000;

    logic                                  i_clk       = 1'b0;
    logic                                  i_rst_n     = 1'b0;
    logic                                  i_cfg_valid = 1'b0;
    logic [iirq_pkg::CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [iirq_pkg::CFG_DATA_W-1:0]       i_cfg_data  = '0;
    logic                                  i_in_valid  = 1'b0;
    logic signed [15:0]                    i_sample_in = '0;
    logic                                  i_out_ready = 1'b0;
    logic                                  o_cfg_ready;
    logic                                  o_in_ready;
    logic                                  o_out_valid;
    logic signed [15:0]                    o_sample_out;
    logic                                  o_saturated;
    int                                    fail_count;
    int                                    pending;
    int                                    cycle_count = 0;
    int                                    sent_count  = 0;
    logic signed [iirq_pkg::COEF_W-1:0]    set_b [0:4];
    logic [iirq_pkg::CFG_DATA_W-1:0]       set_a12;
    logic [iirq_pkg::CFG_DATA_W-1:0]       set_a34;

    always #1 i_clk = ~i_clk;

    iir_order4_direct_form1_q14 uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .o_saturated  (o_saturated)
    );

    iir_order4_direct_form1_q14_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_sample_out (o_sample_out),
        .i_saturated  (o_saturated),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // every fourth stretch of 64 transfers runs without idling
    function automatic int draw_gap(input int n);
        if ((n / 64) % 4 == 1) begin
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [15:0] draw_extreme();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            4:       return 16'h0001;
            default: return 16'h4000;
        endcase
    endfunction

    function automatic logic [15:0] draw_sample();
        case ($urandom_range(0, 9))
            0, 1:    return draw_extreme();
            2, 3:    return 16'($urandom_range(0, 511) - 256);
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // kind 0: full range, kind 1: moderate and mostly stable, else extremes
    function automatic logic [15:0] draw_coef(input int kind, input bit feedback);
        case (kind)
            0:       return 16'($urandom_range(0, 65535));
            1:       return feedback ? 16'($urandom_range(0, 4095) - 2048)
                                     : 16'($urandom_range(0, 16383) - 8192);
            default: return draw_extreme();
        endcase
    endfunction

    task automatic write_reg(input logic [iirq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [iirq_pkg::CFG_DATA_W-1:0] data);
        int gap;
        gap = draw_gap(sent_count);
        if (gap > 0) begin
            i_cfg_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // upper halves of the b writes carry random bits that the block must drop
    task automatic load_coefs(input bit with_unused);
        write_reg(iirq_pkg::REG_B0, {16'($urandom), set_b[0]});
        write_reg(iirq_pkg::REG_B1, {16'($urandom), set_b[1]});
        if (with_unused) begin
            write_reg(UNUSED_REG_IDX, $urandom);
        end
        write_reg(iirq_pkg::REG_B2, {16'($urandom), set_b[2]});
        write_reg(iirq_pkg::REG_B3, {16'($urandom), set_b[3]});
        write_reg(iirq_pkg::REG_B4, {16'($urandom), set_b[4]});
        write_reg(iirq_pkg::REG_A1_A2, set_a12);
        write_reg(iirq_pkg::REG_A3_A4, set_a34);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_coefs(input logic [15:0] b0, input logic [15:0] b_rest,
                             input logic [31:0] a_pair);
        set_b[0] = b0;
        for (int k = 1; k <= 4; k++) begin
            set_b[k] = b_rest;
        end
        set_a12 = a_pair;
        set_a34 = a_pair;
    endtask

    task automatic send_sample(input logic [15:0] x);
        int gap;
        gap = draw_gap(sent_count);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= x;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("iir_order4_direct_form1_q14 test failed");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off that backs up the filter
    initial begin : receiver
        int n;
        int wait_cycles;
        n = 0;
        forever begin
            wait_cycles = (n == HOLD_AT) ? HOLD_CYCLES : draw_gap(n);
            if (wait_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            n++;
        end
    end

    initial begin : stimulus
        int phase_len;
        int kind;
        int target;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // coefficients out of reset are zero
        send_sample(16'h7fff);
        wait_idle();

        // unity gain, with a write to the unused index in between
        set_coefs(16'h4000, 16'h0000, 32'h0000_0000);
        load_coefs(1'b1);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        send_sample(16'h0000);
        send_sample(16'hffff);
        send_sample(16'h0001);
        send_sample(16'h5555);
        send_sample(16'haaaa);
        wait_idle();

        // smallest gain: negative values floor away from zero
        set_coefs(16'h0001, 16'h0000, 32'h0000_0000);
        load_coefs(1'b0);
        send_sample(16'hffff);
        send_sample(16'h4000);
        send_sample(16'hbfff);
        wait_idle();

        // largest gains with the most negative feedback coefficients drive the output into clipping
        set_coefs(16'h7fff, 16'h7fff, 32'h8000_8000);
        load_coefs(1'b0);
        send_sample(16'h7fff);
        send_sample(16'h7fff);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h8000);
        wait_idle();

        set_coefs(16'h8000, 16'h8000, 32'h7fff_7fff);
        load_coefs(1'b0);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h7fff);
        wait_idle();

        target = sent_count + RANDOM_ITEMS;
        phase_len = FIRST_PHASE;
        while (sent_count < target) begin
            kind = $urandom_range(0, 2);
            for (int k = 0; k <= 4; k++) begin
                set_b[k] = draw_coef(kind, 1'b0);
            end
            set_a12 = {draw_coef(kind, 1'b1), draw_coef(kind, 1'b1)};
            set_a34 = {draw_coef(kind, 1'b1), draw_coef(kind, 1'b1)};
            load_coefs($urandom_range(0, 3) == 0);
            repeat (phase_len) send_sample(draw_sample());
            wait_idle();
            phase_len = $urandom_range(60, 220);
        end

        repeat (120) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("iir_order4_direct_form1_q14 test passed");
        end else begin
            $display("iir_order4_direct_form1_q14 test failed");
        end
        $finish;
    end

endmodule
